### hw/rtl/int8_dot_product_accumulator_core_assert.svh
// assertion macros shared by the dot product accumulator checkers
`ifndef INT8_DOT_PRODUCT_ACCUMULATOR_CORE_ASSERT_SVH
`define INT8_DOT_PRODUCT_ACCUMULATOR_CORE_ASSERT_SVH

// implication checked in the same cycle
`define DPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpa check failed in the same cycle");

// implication checked in the next cycle
`define DPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpa check failed one cycle later");

`endif

### hw/rtl/dpa_pkg.sv
// shared types and constants of the int8 dot product accumulator
package dpa_pkg;

    localparam int BYTE_W      = 8;
    localparam int OPND_W      = BYTE_W + 1;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int TERM_W      = PROD_W + 1;
    localparam int ACC_W       = 42;
    localparam int IN_TDATA_W  = 4 * BYTE_W;
    localparam int OUT_PAD_W   = 4;
    localparam int OUT_TDATA_W = 2 * ACC_W + OUT_PAD_W;
    localparam int CFG_IDX_W   = 2;

    localparam int FIFO_DEPTH_DEFAULT = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 2'd1;

    typedef struct packed {
        logic signed_mode;
        logic complex_mode;
    } dpa_cfg_t;

    // one classified element pair waiting for the accumulator
    typedef struct packed {
        logic signed [TERM_W-1:0] term_re;
        logic signed [TERM_W-1:0] term_im;
        logic                     is_complex;
        logic                     last;
    } dpa_entry_t;

endpackage

### hw/rtl/dpa_front.sv
// front end: config registers, operand decode, products and term forming
module dpa_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                              cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dpa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              push_valid,
    input  logic                              push_ready,
    output dpa_pkg::dpa_entry_t               push_entry
);
    import dpa_pkg::*;

    dpa_cfg_t                  cfg_reg;
    logic                      s1_valid_reg;
    logic                      s1_complex_reg;
    logic                      s1_last_reg;
    logic signed [PROD_W-1:0]  p_rr_reg;
    logic signed [PROD_W-1:0]  p_ii_reg;
    logic signed [PROD_W-1:0]  p_ir_reg;
    logic signed [PROD_W-1:0]  p_ri_reg;
    logic signed [OPND_W-1:0]  xr;
    logic signed [OPND_W-1:0]  xi;
    logic signed [OPND_W-1:0]  yr;
    logic signed [OPND_W-1:0]  yi;
    logic                      s1_advance;
    logic                      in_xfer;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIGNED_MODE:  cfg_reg.signed_mode  <= cfg_data;
                CFG_COMPLEX_MODE: cfg_reg.complex_mode <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // extend each byte to nine bits, sign taken from the mode
    function automatic logic signed [OPND_W-1:0] widen(input logic [BYTE_W-1:0] b,
                                                      input logic sgn);
        widen = $signed({sgn & b[BYTE_W-1], b});
    endfunction

    assign xr = widen(s_axis_tdata[0*BYTE_W +: BYTE_W], cfg_reg.signed_mode);
    assign xi = widen(s_axis_tdata[1*BYTE_W +: BYTE_W], cfg_reg.signed_mode);
    assign yr = widen(s_axis_tdata[2*BYTE_W +: BYTE_W], cfg_reg.signed_mode);
    assign yi = widen(s_axis_tdata[3*BYTE_W +: BYTE_W], cfg_reg.signed_mode);

    assign s1_advance    = !s1_valid_reg || push_ready;
    assign s_axis_tready = s1_advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    // product registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            p_rr_reg       <= xr * yr;
            p_ii_reg       <= xi * yi;
            p_ir_reg       <= xi * yr;
            p_ri_reg       <= xr * yi;
            s1_complex_reg <= cfg_reg.complex_mode;
            s1_last_reg    <= s_axis_tlast;
        end
    end

    always_comb
    begin
        push_valid            = s1_valid_reg;
        push_entry.is_complex = s1_complex_reg;
        push_entry.last       = s1_last_reg;
        push_entry.term_im    = TERM_W'(p_ir_reg) - TERM_W'(p_ri_reg);
        if (s1_complex_reg)
        begin
            push_entry.term_re = TERM_W'(p_rr_reg) + TERM_W'(p_ii_reg);
        end
        else
        begin
            push_entry.term_re = TERM_W'(p_rr_reg);
        end
    end

endmodule

### hw/rtl/dpa_fifo.sv
// small register queue between front end and accumulator
module dpa_fifo #(
    parameter int DEPTH = dpa_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  dpa_pkg::dpa_entry_t  push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output dpa_pkg::dpa_entry_t  pop_entry
);
    import dpa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dpa_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/dpa_back.sv
// back end: saturating accumulators and result output register
module dpa_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  dpa_pkg::dpa_entry_t               pop_entry,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import dpa_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [ACC_W-1:0] real_acc_reg;
    logic signed [ACC_W-1:0] imag_acc_reg;
    logic signed [ACC_W-1:0] real_new;
    logic signed [ACC_W-1:0] imag_new;
    logic signed [ACC_W-1:0] real_out_reg;
    logic signed [ACC_W-1:0] imag_out_reg;
    logic                    out_valid_reg;
    logic                    out_free;
    logic                    do_pop;

    // add with clamp to the accumulator range
    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                       input logic signed [TERM_W-1:0] term);
        logic signed [ACC_W:0] s;
        s = (ACC_W + 1)'(acc) + (ACC_W + 1)'(term);
        if (s > (ACC_W + 1)'(ACC_MAX))
        begin
            sat_add = ACC_MAX;
        end
        else if (s < (ACC_W + 1)'(ACC_MIN))
        begin
            sat_add = ACC_MIN;
        end
        else
        begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pop_ready = !pop_entry.last || out_free;
    assign do_pop    = pop_valid && pop_ready;
    assign real_new  = sat_add(real_acc_reg, pop_entry.term_re);
    assign imag_new  = sat_add(imag_acc_reg, pop_entry.term_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_acc_reg  <= '0;
            imag_acc_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= do_pop && pop_entry.last;
            end
            if (do_pop)
            begin
                if (pop_entry.last)
                begin
                    real_acc_reg <= '0;
                    imag_acc_reg <= '0;
                end
                else
                begin
                    real_acc_reg <= real_new;
                    if (pop_entry.is_complex)
                    begin
                        imag_acc_reg <= imag_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && pop_entry.last)
        begin
            real_out_reg <= real_new;
            imag_out_reg <= pop_entry.is_complex ? imag_new : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, imag_out_reg, real_out_reg};

endmodule

### hw/rtl/int8_dot_product_accumulator_core.sv
// int8 dot product accumulator: each pair passes product registers, queue, output register
// one element pair per cycle unless the queue is full; two 42-bit add and clamp loops set it
// a result appears only for the transfer marked tlast, then both sums restart at zero
// output register plus a FIFO_DEPTH entry queue let each side stall on its own
// rst_n is asynchronous active low; clears modes, accumulators, queue and output valid
module int8_dot_product_accumulator_core #(
    parameter int FIFO_DEPTH = dpa_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel, index 0 signed_mode, index 1 complex_mode
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic                              cfg_data,
    // element pair input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dpa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // x_re, x_im, y_re, y_im
    input  logic                              s_axis_tlast,   // last element of the vector
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // real_sum, imag_sum, zero pad
);
    import dpa_pkg::*;

    // front to queue
    logic       push_valid;
    logic       push_ready;
    dpa_entry_t push_entry;
    // queue to back end
    logic       pop_valid;
    logic       pop_ready;
    dpa_entry_t pop_entry;

    // front end decodes bytes by the current modes, registers the four
    // nine by nine products and forms the real and imaginary terms
    dpa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    // short queue decouples the multipliers from the accumulator so a
    // stalled result does not stop the input immediately
    dpa_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // back end: saturating accumulate, non-last terms never wait on the output
    dpa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### hw/rtl/dpa_checker.sv
// port level checker for the dot product accumulator, bound to the top level
`include "int8_dot_product_accumulator_core_assert.svh"

module dpa_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [dpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic                              cfg_data,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tlast,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [dpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import dpa_pkg::*;

    logic       complex_seen_reg;
    logic [7:0] pending_reg;
    logic       last_in;
    logic       result_out;

    assign last_in    = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign result_out = m_axis_tvalid && m_axis_tready;

    // shadow of the complex mode register and of results still owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complex_seen_reg <= 1'b0;
            pending_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && (cfg_index == CFG_COMPLEX_MODE))
            begin
                complex_seen_reg <= cfg_data;
            end
            if (last_in && !result_out)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (result_out && !last_in)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    `DPA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    `DPA_ASSERT_SAME(a_no_spurious_result, clk, rst_n, m_axis_tvalid, pending_reg != 8'd0)

    `DPA_ASSERT_SAME(a_real_mode_imag_zero, clk, rst_n, m_axis_tvalid && !complex_seen_reg,
        m_axis_tdata[2*ACC_W-1:ACC_W] == '0)

endmodule

bind int8_dot_product_accumulator_core dpa_checker u_dpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### sim/tb_top.sv
// self-checking testbench for the int8 dot product accumulator core
`timescale 1ns / 100ps

module tb_top;

    import dpa_pkg::*;

    // timing and run length
    localparam int     CLK_HALF        = 5;
    localparam int     RESET_CYCLES    = 10;
    localparam int     SETTLE_CYCLES   = 8;
    localparam longint CYCLE_LIMIT     = 1000000;
    localparam int     NUM_PHASES      = 10;
    localparam int     ITEMS_PER_PHASE = 160;
    localparam int     HOLD_OFF_PHASE  = 5;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     MAX_REPORTS     = 40;

    // register indexes that no register answers to
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // saturation bounds of the 42-bit sums
    localparam longint SUM_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< (ACC_W - 1));

    typedef struct packed {
        logic [BYTE_W-1:0] x_re;
        logic [BYTE_W-1:0] x_im;
        logic [BYTE_W-1:0] y_re;
        logic [BYTE_W-1:0] y_im;
        logic              last;
    } elem_pair_t;

    typedef struct packed {
        logic [ACC_W-1:0] real_sum;
        logic [ACC_W-1:0] imag_sum;
    } sum_pair_t;

    typedef enum logic {ROW_CONFIG, ROW_PAIR} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic                  reg_value;
        elem_pair_t            pair;
        logic                  typed;      // expected sums written in by hand
        longint                want_re;
        longint                want_im;
    } directed_row_t;

    localparam int NUM_DIRECTED = 22;

    // hand-picked rows: modes after reset, byte extremes, mode changes mid-vector,
    // writes to unused indexes; typed sums only where they are obvious
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // unsigned real, imaginary bytes must be ignored
        '{ROW_PAIR,   2'd0, 1'b0, '{8'hff, 8'haa, 8'hff, 8'h55, 1'b1}, 1'b1, 65025, 0},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, 0, 0},
        '{ROW_CONFIG, CFG_SIGNED_MODE, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 0, 0},
        // signed real extremes
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h80, 8'h00, 8'h80, 8'h00, 1'b1}, 1'b1, 16384, 0},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h80, 8'h00, 8'h7f, 8'h00, 1'b1}, 1'b1, -16256, 0},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h7f, 8'h00, 8'h7f, 8'h00, 1'b0}, 1'b0, 0, 0},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'hff, 8'h00, 8'h01, 8'h00, 1'b1}, 1'b0, 0, 0},
        '{ROW_CONFIG, CFG_COMPLEX_MODE, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 0, 0},
        // signed complex with conjugated y
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h80, 8'h80, 8'h7f, 8'h80, 1'b1}, 1'b1, 128, -32640},
        // complex terms, then real mode before the last element
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h01, 8'h02, 8'h03, 8'h04, 1'b0}, 1'b0, 0, 0},
        '{ROW_CONFIG, CFG_COMPLEX_MODE, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 0, 0},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h05, 8'h00, 8'h06, 8'h00, 1'b1}, 1'b0, 0, 0},
        // real terms, then complex mode before the last element
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h07, 8'h00, 8'h08, 8'h00, 1'b0}, 1'b0, 0, 0},
        '{ROW_CONFIG, CFG_COMPLEX_MODE, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 0, 0},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h01, 8'h01, 8'h01, 8'hff, 1'b1}, 1'b0, 0, 0},
        '{ROW_CONFIG, CFG_SIGNED_MODE, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 0, 0},
        // unsigned complex extremes
        '{ROW_PAIR,   2'd0, 1'b0, '{8'hff, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, 130050, 0},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'h00, 8'hff, 8'hff, 8'h00, 1'b1}, 1'b1, 0, 65025},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'hff, 8'h00, 8'h00, 8'hff, 1'b1}, 1'b1, 0, -65025},
        // writes to unused indexes must leave both modes alone
        '{ROW_CONFIG, CFG_SPARE_2, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 0, 0},
        '{ROW_CONFIG, CFG_SPARE_3, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 0, 0},
        '{ROW_PAIR,   2'd0, 1'b0, '{8'hff, 8'h01, 8'h01, 8'h00, 1'b1}, 1'b1, 255, 1}
    };

    // dut ports
    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic                    cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;    // x_re, x_im, y_re, y_im
    logic                    s_axis_tlast;    // last element of the vector
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;    // real_sum, imag_sum, zero pad

    // predictor state: modes and running sums as the block should hold them
    logic       mode_signed;
    logic       mode_complex;
    longint     acc_re;
    longint     acc_im;

    sum_pair_t  pending_sums [$];   // sums still owed by the block, oldest first
    int         error_count;
    longint     cycle_count = 0;
    bit         hold_off_request;   // raised by the sender, served once by the receiver
    bit         hold_off_served;

    int8_dot_product_accumulator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // watchdog: cycle counter against a generous limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** int8_dot_product_accumulator_core: FAILED **");
        $finish;
    end

    task automatic report_failure(input string msg);
        if (error_count < MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // one byte as an operand under the current sign mode
    function automatic longint byte_operand(input logic [BYTE_W-1:0] raw);
        return mode_signed ? longint'($signed(raw)) : longint'(raw);
    endfunction

    function automatic longint clamp_sum(input longint v);
        if (v > SUM_MAX)
            return SUM_MAX;
        if (v < SUM_MIN)
            return SUM_MIN;
        return v;
    endfunction

    // folds one element pair into the running sums; returns the sums on the last one
    function automatic bit fold_pair(input elem_pair_t p, output sum_pair_t sums);
        longint xr;
        longint xi;
        longint yr;
        longint yi;
        xr = byte_operand(p.x_re);
        xi = byte_operand(p.x_im);
        yr = byte_operand(p.y_re);
        yi = byte_operand(p.y_im);
        if (mode_complex)
        begin
            acc_re = clamp_sum(acc_re + xr * yr + xi * yi);
            acc_im = clamp_sum(acc_im + xi * yr - xr * yi);
        end
        else
        begin
            acc_re = clamp_sum(acc_re + xr * yr);
        end
        sums.real_sum = acc_re[ACC_W-1:0];
        sums.imag_sum = mode_complex ? acc_im[ACC_W-1:0] : '0;
        if (p.last)
        begin
            acc_re = 0;
            acc_im = 0;
        end
        return p.last;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random byte leaning now and then towards the corners
    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 3) != 0)
            return BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h7f;
            3:       return 8'h80;
            default: return 8'hff;
        endcase
    endfunction

    // lets the block run dry: nothing owed, then a settle wait for items without a result
    task automatic wait_until_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic value);
        wait_until_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_SIGNED_MODE)
            mode_signed = value;
        else if (idx == CFG_COMPLEX_MODE)
            mode_complex = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // offers one element pair and records what it should produce once transferred
    task automatic send_pair(input elem_pair_t p, input bit typed, input sum_pair_t typed_sums,
                             input int gap);
        sum_pair_t sums;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.y_im, p.y_re, p.x_im, p.x_re};
        s_axis_tlast  <= p.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (fold_pair(p, sums))
            pending_sums.push_back(typed ? typed_sums : sums);
    endtask

    // result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        sum_pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_sums.size() == 0)
            begin
                report_failure($sformatf("result with nothing expected, real_sum %0d",
                                         $signed(m_axis_tdata[ACC_W-1:0])));
            end
            else
            begin
                want = pending_sums.pop_front();
                if (m_axis_tdata[ACC_W-1:0] !== want.real_sum)
                    report_failure($sformatf("real_sum got %0d expected %0d",
                                             $signed(m_axis_tdata[ACC_W-1:0]),
                                             $signed(want.real_sum)));
                if (m_axis_tdata[2*ACC_W-1:ACC_W] !== want.imag_sum)
                    report_failure($sformatf("imag_sum got %0d expected %0d",
                                             $signed(m_axis_tdata[2*ACC_W-1:ACC_W]),
                                             $signed(want.imag_sum)));
                if (m_axis_tdata[OUT_TDATA_W-1:2*ACC_W] !== '0)
                    report_failure($sformatf("pad bits got %b",
                                             m_axis_tdata[OUT_TDATA_W-1:2*ACC_W]));
            end
        end
    end

    // receiver: random back-pressure in modes, plus one long hold-off on request
    initial
    begin
        int  stall_left;
        int  mode_left;
        int  held;
        bit  always_ready;
        m_axis_tready   = 1'b0;
        hold_off_served = 1'b0;
        stall_left      = 0;
        mode_left       = 0;
        always_ready    = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request && !hold_off_served)
            begin
                // long hold-off so the block fills and stalls its input
                m_axis_tready <= 1'b0;
                for (held = 1; held < HOLD_OFF_CYCLES; held++)
                    @(negedge clk);
                hold_off_served = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    always_ready = ($urandom_range(0, 2) == 0);
                    mode_left    = $urandom_range(50, 300);
                end
                mode_left--;
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end
                else if (always_ready)
                begin
                    m_axis_tready <= 1'b1;
                end
                else
                begin
                    case ($urandom_range(0, 19))
                        0:       stall_left = $urandom_range(10, 40);
                        1, 2, 3: stall_left = 0;
                        default: stall_left = -1;
                    endcase
                    m_axis_tready <= (stall_left < 0);
                    if (stall_left < 0)
                        stall_left = 0;
                end
            end
        end
    end

    // stimulus: reset, directed rows, then random phases
    initial
    begin
        directed_row_t row;
        elem_pair_t    p;
        sum_pair_t     typed_sums;
        int            phase;
        int            n;
        int            vec_left;
        bit            no_gaps;
        logic          next_signed;
        logic          next_complex;

        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tlast     = 1'b0;
        mode_signed      = 1'b0;
        mode_complex     = 1'b0;
        acc_re           = 0;
        acc_im           = 0;
        error_count      = 0;
        hold_off_request = 1'b0;
        vec_left         = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (n = 0; n < NUM_DIRECTED; n++)
        begin
            row = DIRECTED_ROWS[n];
            if (row.kind == ROW_CONFIG)
            begin
                write_register(row.reg_index, row.reg_value);
            end
            else
            begin
                typed_sums.real_sum = row.want_re[ACC_W-1:0];
                typed_sums.imag_sum = row.want_im[ACC_W-1:0];
                send_pair(row.pair, row.typed, typed_sums, pick_gap());
            end
        end

        // random phases; the first four walk every mode setting, and a vector
        // left open at a phase end carries the new modes into its remaining items
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 4)
            begin
                next_signed  = phase[0];
                next_complex = phase[1];
            end
            else
            begin
                next_signed  = 1'($urandom_range(0, 1));
                next_complex = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 1))
            begin
                write_register(CFG_SIGNED_MODE, next_signed);
                write_register(CFG_COMPLEX_MODE, next_complex);
            end
            else
            begin
                write_register(CFG_COMPLEX_MODE, next_complex);
                write_register(CFG_SIGNED_MODE, next_signed);
            end
            if ($urandom_range(0, 3) == 0)
                write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                               1'($urandom_range(0, 1)));

            no_gaps = (phase == HOLD_OFF_PHASE) || ($urandom_range(0, 3) == 0);
            if (phase == HOLD_OFF_PHASE)
                hold_off_request = 1'b1;

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (vec_left == 0)
                begin
                    if (phase == HOLD_OFF_PHASE)
                        vec_left = $urandom_range(1, 2);
                    else if ($urandom_range(0, 19) < 16)
                        vec_left = $urandom_range(1, 8);
                    else if ($urandom_range(0, 3) != 0)
                        vec_left = $urandom_range(9, 40);
                    else
                        vec_left = $urandom_range(41, 200);
                end
                vec_left--;
                p.x_re = pick_byte();
                p.x_im = pick_byte();
                p.y_re = pick_byte();
                p.y_im = pick_byte();
                p.last = (vec_left == 0);
                send_pair(p, 1'b0, '0, no_gaps ? 0 : pick_gap());
            end
        end

        // close any vector still open
        if (vec_left != 0)
        begin
            p.x_re = pick_byte();
            p.x_im = pick_byte();
            p.y_re = pick_byte();
            p.y_im = pick_byte();
            p.last = 1'b1;
            send_pair(p, 1'b0, '0, 0);
        end

        // drain, then watch a while for stray results
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_sums.size() == 0)
            $display("** int8_dot_product_accumulator_core: PASSED **");
        else
            $display("** int8_dot_product_accumulator_core: FAILED **");
        $finish;
    end

endmodule
